[design/irmpd_pkg.sv]
// Shared types and constants of the IR Manchester pulse decoder.
package irmpd_pkg;

    localparam int DURATION_BITS = 15;
    localparam int HBT_W         = 15;
    localparam int TOL_W         = 8;
    localparam int SKIP_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;

    localparam int IN_BITS       = 2 + 2 * DURATION_BITS;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = 16;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HALF_BITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MODE       = 2'd3;

    localparam logic [HBT_W-1:0]  RST_HALF_BIT_TIME   = 15'd889;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE       = 8'd100;
    localparam logic [SKIP_W-1:0] RST_START_HALF_BITS = 4'd2;

    typedef struct packed {
        logic [HBT_W-1:0]  half_bit_time;
        logic [TOL_W-1:0]  tolerance;
        logic [SKIP_W-1:0] start_half_bits;
        logic              diff_mode;
    } t_cfg;

    // One classified symbol: half-bit counts per half, 0 for an absent second half
    typedef struct packed {
        logic       l0;
        logic [1:0] n0;
        logic       l1;
        logic [1:0] n1;
        logic       fend;
        logic       bad;
    } t_sym;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] bit_count;
        logic       frame_last;
        logic       error;
    } t_result;

endpackage

[design/irmpd_front.sv]
// Front end: accepts pulse symbols and classes each duration by window test.
module irmpd_front import irmpd_pkg::*; (
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    input  logic                  i_last,
    output logic                  o_push,
    output t_sym                  o_sym,
    input  logic                  i_full
);

    // 0 = fits neither window, 1 = single, 2 = double
    function automatic logic [1:0] classify(input logic [DURATION_BITS-1:0] d,
                                            input logic [HBT_W-1:0] t,
                                            input logic [TOL_W-1:0] tol);
        logic [16:0] dx;
        logic [16:0] lo1;
        logic [16:0] hi1;
        logic [16:0] two_t;
        logic [16:0] two_tol;
        logic [16:0] lo2;
        logic [16:0] hi2;
        logic [1:0]  cls;
        dx      = 17'(d);
        hi1     = 17'(t) + 17'(tol);
        lo1     = (17'(t) > 17'(tol)) ? (17'(t) - 17'(tol)) : 17'd0;
        two_t   = {1'b0, t, 1'b0};
        two_tol = {8'd0, tol, 1'b0};
        hi2     = two_t + two_tol;
        lo2     = (two_t > two_tol) ? (two_t - two_tol) : 17'd0;
        if (dx >= lo1 && dx <= hi1) begin
            cls = 2'd1;
        end else if (dx >= lo2 && dx <= hi2) begin
            cls = 2'd2;
        end else begin
            cls = 2'd0;
        end
        return cls;
    endfunction

    logic                     l0;
    logic                     l1;
    logic [DURATION_BITS-1:0] d0;
    logic [DURATION_BITS-1:0] d1;
    logic [1:0]               c0;
    logic [1:0]               c1;
    logic                     absent;

    assign l0 = i_data[0];
    assign d0 = i_data[DURATION_BITS:1];
    assign l1 = i_data[DURATION_BITS+1];
    assign d1 = i_data[2*DURATION_BITS+1:DURATION_BITS+2];

    assign absent = (d1 == '0);
    assign c0 = classify(d0, i_cfg.half_bit_time, i_cfg.tolerance);
    assign c1 = absent ? 2'd0 : classify(d1, i_cfg.half_bit_time, i_cfg.tolerance);

    assign o_ready = i_rst_n && !i_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_sym.l0   = l0;
        o_sym.n0   = c0;
        o_sym.l1   = l1;
        o_sym.n1   = c1;
        o_sym.fend = i_last;
        o_sym.bad  = (c0 == 2'd0) || (!absent && c1 == 2'd0);
    end

endmodule

[design/irmpd_queue.sv]
// Short queue of classified symbols between front end and decoder.
module irmpd_queue import irmpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_sym i_sym,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_sym o_sym
);

    t_sym            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_sym   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_sym;
        end
    end

endmodule

[design/irmpd_back.sv]
// Back end: expands half-bits, pairs them into bits, packs bytes and drives results.
module irmpd_back import irmpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_sym    i_sym,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [SKIP_W-1:0] r_skip_left;
    logic              r_half_pending;
    logic              r_pending_level;
    logic [7:0]        r_bit_shift;
    logic [3:0]        r_bits_held;
    logic              r_dropping;
    logic              r_frame_started;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_extra_valid;
    t_result           r_extra;

    logic [SKIP_W-1:0] n_skip_left;
    logic              n_half_pending;
    logic              n_pending_level;
    logic [7:0]        n_bit_shift;
    logic [3:0]        n_bits_held;
    logic              n_dropping;
    logic              n_frame_started;
    t_result           res [2];
    logic [1:0]        nres;

    logic out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && !r_extra_valid && out_free;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        logic [2:0] nhalf;
        logic       lvl;
        logic       bit_v;
        n_skip_left     = r_frame_started ? r_skip_left : i_cfg.start_half_bits;
        n_half_pending  = r_half_pending;
        n_pending_level = r_pending_level;
        n_bit_shift     = r_bit_shift;
        n_bits_held     = r_bits_held;
        n_dropping      = r_dropping;
        n_frame_started = 1'b1;
        res[0]          = '0;
        res[1]          = '0;
        nres            = 2'd0;
        nhalf           = {1'b0, i_sym.n0} + {1'b0, i_sym.n1};
        lvl             = 1'b0;
        bit_v           = 1'b0;

        if (r_dropping) begin
            if (i_sym.fend) begin
                n_skip_left     = '0;
                n_half_pending  = 1'b0;
                n_pending_level = 1'b0;
                n_bit_shift     = '0;
                n_bits_held     = '0;
                n_dropping      = 1'b0;
                n_frame_started = 1'b0;
            end
        end else if (i_sym.bad) begin
            res[0]          = '{data_byte: 8'd0, bit_count: 4'd0, frame_last: 1'b1, error: 1'b1};
            nres            = 2'd1;
            n_skip_left     = '0;
            n_half_pending  = 1'b0;
            n_pending_level = 1'b0;
            n_bit_shift     = '0;
            n_bits_held     = '0;
            n_dropping      = !i_sym.fend;
            n_frame_started = !i_sym.fend;
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < nhalf) begin
                    lvl = (3'(k) < {1'b0, i_sym.n0}) ? i_sym.l0 : i_sym.l1;
                    if (n_skip_left != '0) begin
                        n_skip_left = n_skip_left - 1'b1;
                    end else if (!n_half_pending) begin
                        n_pending_level = lvl;
                        n_half_pending  = 1'b1;
                    end else begin
                        bit_v = i_cfg.diff_mode ? (n_pending_level == lvl)
                                                : (!n_pending_level && lvl);
                        n_half_pending = 1'b0;
                        n_bit_shift    = {n_bit_shift[6:0], bit_v};
                        n_bits_held    = n_bits_held + 1'b1;
                        if (n_bits_held == 4'd8) begin
                            res[nres[0]] = '{data_byte: n_bit_shift, bit_count: 4'd8,
                                             frame_last: 1'b0, error: 1'b0};
                            nres         = nres + 1'b1;
                            n_bit_shift  = '0;
                            n_bits_held  = '0;
                        end
                    end
                end
            end

            if (i_sym.fend) begin
                // pair a dangling half-bit with a low level
                if (n_half_pending) begin
                    bit_v          = i_cfg.diff_mode && !n_pending_level;
                    n_half_pending = 1'b0;
                    n_bit_shift    = {n_bit_shift[6:0], bit_v};
                    n_bits_held    = n_bits_held + 1'b1;
                    if (n_bits_held == 4'd8) begin
                        res[nres[0]] = '{data_byte: n_bit_shift, bit_count: 4'd8,
                                         frame_last: 1'b0, error: 1'b0};
                        nres         = nres + 1'b1;
                        n_bit_shift  = '0;
                        n_bits_held  = '0;
                    end
                end
                if (n_bits_held != '0) begin
                    res[nres[0]] = '{data_byte: 8'(n_bit_shift << 3'(4'd8 - n_bits_held)),
                                     bit_count: n_bits_held, frame_last: 1'b1, error: 1'b0};
                    nres         = nres + 1'b1;
                end else if (nres != 2'd0) begin
                    res[nres[0] ^ 1'b1].frame_last = 1'b1;
                end else begin
                    res[0] = '{data_byte: 8'd0, bit_count: 4'd0, frame_last: 1'b1, error: 1'b0};
                    nres   = 2'd1;
                end
                n_skip_left     = '0;
                n_pending_level = 1'b0;
                n_bit_shift     = '0;
                n_bits_held     = '0;
                n_dropping      = 1'b0;
                n_frame_started = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left     <= '0;
            r_half_pending  <= 1'b0;
            r_pending_level <= 1'b0;
            r_bit_shift     <= '0;
            r_bits_held     <= '0;
            r_dropping      <= 1'b0;
            r_frame_started <= 1'b0;
            r_out_valid     <= 1'b0;
            r_extra_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_skip_left     <= n_skip_left;
                r_half_pending  <= n_half_pending;
                r_pending_level <= n_pending_level;
                r_bit_shift     <= n_bit_shift;
                r_bits_held     <= n_bits_held;
                r_dropping      <= n_dropping;
                r_frame_started <= n_frame_started;
                r_out_valid     <= (nres != 2'd0);
                r_extra_valid   <= (nres == 2'd2);
            end else if (out_free) begin
                // advance the held second result into the output register
                r_out_valid   <= r_extra_valid;
                r_extra_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out   <= res[0];
            r_extra <= res[1];
        end else if (out_free && r_extra_valid) begin
            r_out <= r_extra;
        end
    end

endmodule

[design/ir_manchester_pulse_decoder.sv]
// Top level of the IR Manchester pulse decoder: configuration registers and wiring.
//
// Usage:
//   s_axis takes one captured pulse symbol per transaction: two level/duration
//   halves in tdata and the frame's last symbol marked by tlast. m_axis returns
//   decoded bytes, MSB first, with the valid bit count; tlast marks the frame's
//   final result and tuser flags a duration that fit neither window (frame
//   aborted, later symbols up to the frame end give nothing).
//   The configuration channel writes half_bit_time (0), tolerance (1),
//   start_half_bits (2) and diff_mode (3); always ready, use only while idle.
// Timing:
//   A symbol is written into the queue when it is accepted; the decoder works on
//   the queue head and registers its first result for m_axis when it pops it.
//   While m_axis is ready, one symbol per cycle is sustained; a symbol that
//   yields two results (a full byte plus the frame-end flush) holds the
//   decoder while the second result moves to the output register.
// Reset and stall:
//   Reset restores the default registers and clears decode state and queue.
//   When m_axis stalls, results hold; the four-entry symbol queue fills and
//   then s_axis_tready drops.
module ir_manchester_pulse_decoder import irmpd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [0] first_level, [15:1] first_duration, [16] second_level,
    // [31:17] second_duration
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,

    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] data_byte, [11:8] bit_count, [15:12] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    // [0] error
    output logic                   o_m_axis_tuser,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_sym    front_sym;
    t_sym    queue_sym;
    logic    front_push;
    logic    queue_full;
    logic    queue_valid;
    logic    back_pop;
    t_result back_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_time   <= RST_HALF_BIT_TIME;
            r_cfg.tolerance       <= RST_TOLERANCE;
            r_cfg.start_half_bits <= RST_START_HALF_BITS;
            r_cfg.diff_mode       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_BIT_TIME:   r_cfg.half_bit_time   <= i_cfg_data[HBT_W-1:0];
                CFG_TOLERANCE:       r_cfg.tolerance       <= i_cfg_data[TOL_W-1:0];
                CFG_START_HALF_BITS: r_cfg.start_half_bits <= i_cfg_data[SKIP_W-1:0];
                CFG_DIFF_MODE:       r_cfg.diff_mode       <= i_cfg_data[0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    irmpd_front u_front (
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_push  (front_push),
        .o_sym   (front_sym),
        .i_full  (queue_full)
    );

    irmpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_sym   (front_sym),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_sym   (queue_sym)
    );

    irmpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (queue_valid),
        .i_sym    (queue_sym),
        .o_pop    (back_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (back_result)
    );

    assign o_m_axis_tdata = {4'd0, back_result.bit_count, back_result.data_byte};
    assign o_m_axis_tlast = back_result.frame_last;
    assign o_m_axis_tuser = back_result.error;

endmodule
